>>> design/gwm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package gwm_pkg;

    localparam int SAMPLE_BITS = 16;
    localparam int IDX_BITS    = 12;
    localparam int CTR_BITS    = 16;
    localparam int RATE_BITS   = 32;
    localparam int TAB_FRAC    = 15;
    localparam int SEG_BITS    = 14;
    localparam int CFG_IDX_BITS = 2;

    // register indexes of the configuration port
    localparam logic [CFG_IDX_BITS-1:0] CFG_CENTER_ROW = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_CENTER_COL = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_EXP_RATE   = 2'd2;

    typedef struct packed {
        logic        [IDX_BITS-1:0]    pixel_row;
        logic        [IDX_BITS-1:0]    pixel_col;
        logic signed [SAMPLE_BITS-1:0] in_real;
        logic signed [SAMPLE_BITS-1:0] in_imag;
    } in_item_t;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] out_real;
        logic signed [SAMPLE_BITS-1:0] out_imag;
    } out_item_t;

    // item as it waits between front and back
    typedef struct packed {
        logic                          pass;
        logic        [CTR_BITS-1:0]    abs_dr;
        logic        [CTR_BITS-1:0]    abs_dc;
        logic signed [SAMPLE_BITS-1:0] re;
        logic signed [SAMPLE_BITS-1:0] im;
    } q_entry_t;

    // round(32768 * exp(-k/4)), Q1.15
    function automatic logic [15:0] gwm_exp_tab(input logic [6:0] k);
        logic [15:0] t;
        case (k)
            7'd0:  t = 16'd32768;
            7'd1:  t = 16'd25520;
            7'd2:  t = 16'd19875;
            7'd3:  t = 16'd15479;
            7'd4:  t = 16'd12055;
            7'd5:  t = 16'd9388;
            7'd6:  t = 16'd7312;
            7'd7:  t = 16'd5694;
            7'd8:  t = 16'd4435;
            7'd9:  t = 16'd3454;
            7'd10: t = 16'd2690;
            7'd11: t = 16'd2095;
            7'd12: t = 16'd1631;
            7'd13: t = 16'd1271;
            7'd14: t = 16'd990;
            7'd15: t = 16'd771;
            7'd16: t = 16'd600;
            7'd17: t = 16'd467;
            7'd18: t = 16'd364;
            7'd19: t = 16'd283;
            7'd20: t = 16'd221;
            7'd21: t = 16'd172;
            7'd22: t = 16'd134;
            7'd23: t = 16'd104;
            7'd24: t = 16'd81;
            7'd25: t = 16'd63;
            7'd26: t = 16'd49;
            7'd27: t = 16'd38;
            7'd28: t = 16'd30;
            7'd29: t = 16'd23;
            7'd30: t = 16'd18;
            7'd31: t = 16'd14;
            7'd32: t = 16'd11;
            7'd33: t = 16'd9;
            7'd34: t = 16'd7;
            7'd35: t = 16'd5;
            7'd36: t = 16'd4;
            7'd37: t = 16'd3;
            7'd38: t = 16'd2;
            7'd39: t = 16'd2;
            7'd40: t = 16'd1;
            7'd41: t = 16'd1;
            7'd42: t = 16'd1;
            7'd43: t = 16'd1;
            7'd44: t = 16'd1;
            default: t = 16'd0;
        endcase
        return t;
    endfunction

endpackage

`default_nettype wire

>>> design/gwm_front.sv
`timescale 1ns / 1ps
`default_nettype none

module gwm_front
    import gwm_pkg::*;
#(
    parameter int MAX_DIM = 4096
)
(
    input  wire in_item_t              item,
    input  wire logic [CTR_BITS-1:0]   center_row_q4,
    input  wire logic [CTR_BITS-1:0]   center_col_q4,
    input  wire logic [RATE_BITS-1:0]  exp_rate,
    output q_entry_t                   entry
);

    localparam logic [16:0] IDX_MAX = 17'(MAX_DIM - 1);

    logic [IDX_BITS-1:0] row_c;
    logic [IDX_BITS-1:0] col_c;
    logic signed [CTR_BITS:0] dr;
    logic signed [CTR_BITS:0] dc;

    always_comb
    begin
        // clamp indexes beyond the frame
        row_c = ({5'b0, item.pixel_row} > IDX_MAX) ? IDX_MAX[IDX_BITS-1:0] : item.pixel_row;
        col_c = ({5'b0, item.pixel_col} > IDX_MAX) ? IDX_MAX[IDX_BITS-1:0] : item.pixel_col;
        dr = $signed({1'b0, row_c, 4'b0}) - $signed({1'b0, center_row_q4});
        dc = $signed({1'b0, col_c, 4'b0}) - $signed({1'b0, center_col_q4});
        entry.abs_dr = dr[CTR_BITS] ? CTR_BITS'(-dr) : dr[CTR_BITS-1:0];
        entry.abs_dc = dc[CTR_BITS] ? CTR_BITS'(-dc) : dc[CTR_BITS-1:0];
        entry.pass   = (exp_rate == '0);
        entry.re     = item.in_real;
        entry.im     = item.in_imag;
    end

endmodule

`default_nettype wire

>>> design/gwm_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module gwm_queue
    import gwm_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     push,
    input  wire q_entry_t push_data,
    output logic          full,
    input  wire logic     pop,
    output logic          nonempty,
    output q_entry_t      pop_data
);

    q_entry_t   slot_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic [1:0] count_next;

    assign full     = (count_reg == 2'd2);
    assign nonempty = (count_reg != 2'd0);
    assign pop_data = slot_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

>>> design/gwm_back.sv
`timescale 1ns / 1ps
`default_nettype none

module gwm_back
    import gwm_pkg::*;
#(
    parameter int COEF_BITS = 16
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic [RATE_BITS-1:0] exp_rate,
    input  wire logic                 q_nonempty,
    input  wire q_entry_t             q_data,
    output logic                      q_pop,
    output logic                      out_valid,
    input  wire logic                 out_stall,
    output out_item_t                 out_item
);

    localparam int NST       = 8;
    localparam int COEF_FRAC = COEF_BITS - 1;
    localparam int PW        = SAMPLE_BITS + COEF_BITS + 1;
    localparam logic signed [PW:0] ROUND  = (PW+1)'(2 ** (COEF_FRAC - 1));
    localparam logic signed [PW:0] SAT_HI = (PW+1)'(2 ** (SAMPLE_BITS - 1) - 1);
    localparam logic signed [PW:0] SAT_LO = -SAT_HI - (PW+1)'(1);

    logic [NST-1:0] v_reg;
    logic [NST-1:0] rdy;

    // sample and bypass flag ride along every stage up to the output register
    logic                          pass_reg [NST-1];
    logic signed [SAMPLE_BITS-1:0] re_reg   [NST-1];
    logic signed [SAMPLE_BITS-1:0] im_reg   [NST-1];

    logic [31:0]          sq_r_reg, sq_c_reg;
    logic [32:0]          r2_reg;
    logic [48:0]          ph_reg, pl_reg;
    logic                 zero4_reg, zero5_reg;
    logic [5:0]           k_reg;
    logic [SEG_BITS-1:0]  f_reg;
    logic [15:0]          t0_reg;
    logic [26:0]          dprod_reg;
    logic [COEF_BITS-1:0] coef_reg;
    logic signed [PW-1:0] pr_reg, pi_reg;
    out_item_t            out_reg;

    logic [64:0]          prod;
    logic [15:0]          t0;
    logic [15:0]          t1;
    logic [12:0]          tdif;
    logic [27:0]          corr_sum;
    logic [15:0]          c_lin;
    logic [COEF_BITS-1:0] c_scaled;
    logic signed [PW:0]   rr, ri;
    logic signed [PW:0]   qr, qi;

    // a stage takes new data when it is empty or its content moves on
    always_comb
    begin
        rdy[NST-1] = !v_reg[NST-1] || !out_stall;
        for (int i = NST - 2; i >= 0; i--)
        begin
            rdy[i] = !v_reg[i] || rdy[i+1];
        end
    end

    assign q_pop     = q_nonempty && rdy[0];
    assign out_valid = v_reg[NST-1];
    assign out_item  = out_reg;

    always_comb
    begin
        prod  = {pl_reg[48:0] + 65'd0} + {ph_reg, 16'b0};
        t0    = gwm_exp_tab({1'b0, k_reg});
        t1    = gwm_exp_tab({1'b0, k_reg} + 7'd1);
        tdif  = 13'(t0 - t1);
        corr_sum = {1'b0, dprod_reg} + 28'(2 ** (SEG_BITS - 1));
        c_lin = t0_reg - {2'b0, corr_sum[27:SEG_BITS]};
        rr    = {pr_reg[PW-1], pr_reg} + ROUND;
        ri    = {pi_reg[PW-1], pi_reg} + ROUND;
        qr    = rr >>> COEF_FRAC;
        qi    = ri >>> COEF_FRAC;
    end

    generate
        if (COEF_FRAC >= TAB_FRAC)
        begin : g_up
            assign c_scaled = COEF_BITS'(c_lin) << (COEF_FRAC - TAB_FRAC);
        end
        else
        begin : g_down
            localparam int SH = TAB_FRAC - COEF_FRAC;
            logic [16:0] c_half;
            assign c_half   = {1'b0, c_lin} + 17'(2 ** (SH - 1));
            assign c_scaled = COEF_BITS'(c_half >> SH);
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (rdy[0])
            begin
                v_reg[0] <= q_nonempty;
            end
            for (int i = 1; i < NST; i++)
            begin
                if (rdy[i])
                begin
                    v_reg[i] <= v_reg[i-1];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy[0])
        begin
            pass_reg[0] <= q_data.pass;
            re_reg[0]   <= q_data.re;
            im_reg[0]   <= q_data.im;
            sq_r_reg    <= q_data.abs_dr * q_data.abs_dr;
            sq_c_reg    <= q_data.abs_dc * q_data.abs_dc;
        end
        for (int i = 1; i < NST - 1; i++)
        begin
            if (rdy[i])
            begin
                pass_reg[i] <= pass_reg[i-1];
                re_reg[i]   <= re_reg[i-1];
                im_reg[i]   <= im_reg[i-1];
            end
        end
        if (rdy[1])
        begin
            r2_reg <= {1'b0, sq_r_reg} + {1'b0, sq_c_reg};
        end
        if (rdy[2])
        begin
            // rate split in halves to keep each product narrow
            ph_reg <= r2_reg * exp_rate[31:16];
            pl_reg <= r2_reg * exp_rate[15:0];
        end
        if (rdy[3])
        begin
            // exponent argument of sixteen or more gives a zero coefficient
            zero4_reg <= |prod[64:44];
            k_reg     <= prod[43:38];
            f_reg     <= prod[37:24];
        end
        if (rdy[4])
        begin
            zero5_reg <= zero4_reg;
            t0_reg    <= t0;
            dprod_reg <= tdif * f_reg;
        end
        if (rdy[5])
        begin
            coef_reg <= zero5_reg ? '0 : c_scaled;
        end
        if (rdy[6])
        begin
            pr_reg <= re_reg[5] * $signed({1'b0, coef_reg});
            pi_reg <= im_reg[5] * $signed({1'b0, coef_reg});
        end
        if (rdy[7])
        begin
            if (pass_reg[6])
            begin
                out_reg.out_real <= re_reg[6];
                out_reg.out_imag <= im_reg[6];
            end
            else
            begin
                out_reg.out_real <= (qr > SAT_HI) ? SAMPLE_BITS'(SAT_HI) :
                                    (qr < SAT_LO) ? SAMPLE_BITS'(SAT_LO) :
                                    SAMPLE_BITS'(qr);
                out_reg.out_imag <= (qi > SAT_HI) ? SAMPLE_BITS'(SAT_HI) :
                                    (qi < SAT_LO) ? SAMPLE_BITS'(SAT_LO) :
                                    SAMPLE_BITS'(qi);
            end
        end
    end

endmodule

`default_nettype wire

>>> design/gaussian_window_multiply.sv
`timescale 1ns / 1ps
`default_nettype none
// An accepted item waits in the queue, then passes the back pipeline stages to the output register.
// Throughput: one item per cycle while the output does not stall; the eight-stage back pipeline and a two-entry queue
// let input and output stall independently.
// Reset: rst_n clears the queue, all stage valid flags and the three registers to zero.
// No clearing pass: the block accepts items from the first cycle after reset.

module gaussian_window_multiply
    import gwm_pkg::*;
#(
    parameter int MAX_DIM   = 4096,
    parameter int COEF_BITS = 16
)
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    in_valid,
    output logic                         in_stall,
    input  wire in_item_t                in_item,
    output logic                         out_valid,
    input  wire logic                    out_stall,
    output out_item_t                    out_item,
    input  wire logic                    cfg_valid,
    output logic                         cfg_ready,
    input  wire logic [CFG_IDX_BITS-1:0] cfg_index,
    input  wire logic [RATE_BITS-1:0]    cfg_data
);

    logic [CTR_BITS-1:0]  center_row_reg;
    logic [CTR_BITS-1:0]  center_col_reg;
    logic [RATE_BITS-1:0] exp_rate_reg;

    q_entry_t entry;
    q_entry_t q_data;
    logic     q_full;
    logic     q_nonempty;
    logic     q_pop;

    assign cfg_ready = 1'b1;
    assign in_stall  = q_full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            center_row_reg <= '0;
            center_col_reg <= '0;
            exp_rate_reg   <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_CENTER_ROW: center_row_reg <= cfg_data[CTR_BITS-1:0];
                CFG_CENTER_COL: center_col_reg <= cfg_data[CTR_BITS-1:0];
                CFG_EXP_RATE:   exp_rate_reg   <= cfg_data;
                default:        ;  // drop writes to unknown registers
            endcase
        end
    end

    gwm_front #(
        .MAX_DIM (MAX_DIM)
    ) u_front (
        .item          (in_item),
        .center_row_q4 (center_row_reg),
        .center_col_q4 (center_col_reg),
        .exp_rate      (exp_rate_reg),
        .entry         (entry)
    );

    gwm_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (in_valid && !q_full),
        .push_data (entry),
        .full      (q_full),
        .pop       (q_pop),
        .nonempty  (q_nonempty),
        .pop_data  (q_data)
    );

    gwm_back #(
        .COEF_BITS (COEF_BITS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .exp_rate   (exp_rate_reg),
        .q_nonempty (q_nonempty),
        .q_data     (q_data),
        .q_pop      (q_pop),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_item   (out_item)
    );

endmodule

`default_nettype wire
